// File: hw/rtl/sbs_pkg.sv
// Shared types, widths, codes and defaults of the spike bucket scatter block.
package sbs_pkg;

    localparam int FUNC_W  = 3;
    localparam int SPIKE_W = 9;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 4;
    localparam int ENTRY_W = 15;
    localparam int SLOT_W  = 4;
    localparam int XY_W    = 6;
    localparam int DATA_W  = 15;
    localparam int QUOT_W  = 14;
    localparam int CNT_W   = 10;
    localparam int XYSZ_W  = 7;
    localparam int FAN_W   = 5;
    localparam int DEP_W   = 5;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int DEF_NUM_SPIKE_IDS = 256;
    localparam int DEF_MAX_FANOUT    = 16;
    localparam int DEF_MAX_XY        = 64;
    localparam int DEF_MAX_DEPTH     = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0] COUNT_SAT = '1;

    localparam logic [XYSZ_W-1:0] RST_XY_SIZE = 7'd64;
    localparam logic [FAN_W-1:0]  RST_FANOUT  = 5'd16;
    localparam logic [DEP_W-1:0]  RST_DEPTH   = 5'd16;

    typedef enum logic [1:0] {
        REG_XY_SIZE = 2'd0,
        REG_FANOUT  = 2'd1,
        REG_DEPTH   = 2'd2
    } reg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE      = 3'd0,
        FUNC_CLEAR      = 3'd1,
        FUNC_SPIKE      = 3'd2,
        FUNC_READ_SLOT  = 3'd3,
        FUNC_READ_COUNT = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_WRITE      = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_SPIKE      = 3'd3,
        OP_READ_SLOT  = 3'd4,
        OP_READ_COUNT = 3'd5
    } op_t;

    // Effective (saturated) configuration.
    typedef struct packed {
        logic [XYSZ_W-1:0] xy;
        logic [FAN_W-1:0]  fanout;
        logic [DEP_W-1:0]  depth;
    } cfg_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        op_t                op;
        logic               bad;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [ENTRY_W-1:0] entry;
        logic [SLOT_W-1:0]  slot;
        logic [XY_W-1:0]    xy;
    } cmd_t;

endpackage

// File: hw/rtl/spike_bucket_scatter_top.sv
// Top level of the spike bucket scatter block: configuration registers and the front/queue/back chain.
//
//  Channel  | Signals                                                | Direction
//  ---------+--------------------------------------------------------+----------
//  input    | in_valid, in_ready, func, spike_id, table_row,         | into block
//           | table_col, table_entry, read_slot, read_xy             |
//  output   | out_valid, out_ready, read_data, overflow, bad_index   | out of block
//  config   | psel, penable, pwrite, paddr, pwdata, prdata, pready   | APB slave
//
// Each input transaction yields exactly one output transaction. Table writes,
// clears and items that do nothing finish in S_EXEC of the back end; reads go on
// to S_RDWAIT. A spike walks the table: each non-negative entry goes through the
// table read, the one-bit-per-cycle restoring divider (14 steps) and the counter
// read-modify-write, while a skipped (negative) entry takes only the table read.
// Reset clears the queue, the fill counters' valid bits and the overflow flag; no
// clearing pass is needed. The front end keeps accepting transactions into a short
// queue, until it is full, while the back end works or while a finished result waits to be taken.
module spike_bucket_scatter_top #(
    parameter int NUM_SPIKE_IDS = sbs_pkg::DEF_NUM_SPIKE_IDS,
    parameter int MAX_FANOUT    = sbs_pkg::DEF_MAX_FANOUT,
    parameter int MAX_XY        = sbs_pkg::DEF_MAX_XY,
    parameter int MAX_DEPTH     = sbs_pkg::DEF_MAX_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [sbs_pkg::FUNC_W-1:0]            func,
    input  logic signed [sbs_pkg::SPIKE_W-1:0]    spike_id,
    input  logic [sbs_pkg::ROW_W-1:0]             table_row,
    input  logic [sbs_pkg::COL_W-1:0]             table_col,
    input  logic signed [sbs_pkg::ENTRY_W-1:0]    table_entry,
    input  logic [sbs_pkg::SLOT_W-1:0]            read_slot,
    input  logic [sbs_pkg::XY_W-1:0]              read_xy,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sbs_pkg::DATA_W-1:0]     read_data,
    output logic                                  overflow,
    output logic                                  bad_index,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sbs_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [sbs_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [sbs_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    // Raw register contents, exactly as written.
    logic [sbs_pkg::XYSZ_W-1:0] xy_size_reg;
    logic [sbs_pkg::FAN_W-1:0]  fanout_reg;
    logic [sbs_pkg::DEP_W-1:0]  depth_reg;
    logic                       wr_en;
    sbs_pkg::reg_idx_t          reg_idx;
    sbs_pkg::cfg_t              cfg;

    logic                       push_valid;
    logic                       push_ready;
    sbs_pkg::cmd_t              push_cmd;
    logic                       pop_valid;
    logic                       pop_ready;
    sbs_pkg::cmd_t              pop_cmd;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = sbs_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xy_size_reg <= sbs_pkg::RST_XY_SIZE;
            fanout_reg  <= sbs_pkg::RST_FANOUT;
            depth_reg   <= sbs_pkg::RST_DEPTH;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sbs_pkg::REG_XY_SIZE: xy_size_reg <= pwdata[sbs_pkg::XYSZ_W-1:0];
                sbs_pkg::REG_FANOUT:  fanout_reg  <= pwdata[sbs_pkg::FAN_W-1:0];
                sbs_pkg::REG_DEPTH:   depth_reg   <= pwdata[sbs_pkg::DEP_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sbs_pkg::REG_XY_SIZE: prdata = sbs_pkg::APB_DATA_W'(xy_size_reg);
            sbs_pkg::REG_FANOUT:  prdata = sbs_pkg::APB_DATA_W'(fanout_reg);
            sbs_pkg::REG_DEPTH:   prdata = sbs_pkg::APB_DATA_W'(depth_reg);
            default:              prdata = '0;
        endcase
    end

    // Saturate the registers into the ranges that the datapath supports. A zero
    // position count is treated as one; zero fanout walks nothing and zero depth
    // drops every bucket write.
    always_comb
    begin
        if (xy_size_reg == '0)
            cfg.xy = sbs_pkg::XYSZ_W'(1);
        else if (32'(xy_size_reg) > MAX_XY)
            cfg.xy = sbs_pkg::XYSZ_W'(MAX_XY);
        else
            cfg.xy = xy_size_reg;
        if (32'(fanout_reg) > MAX_FANOUT)
            cfg.fanout = sbs_pkg::FAN_W'(MAX_FANOUT);
        else
            cfg.fanout = fanout_reg;
        if (32'(depth_reg) > MAX_DEPTH)
            cfg.depth = sbs_pkg::DEP_W'(MAX_DEPTH);
        else
            cfg.depth = depth_reg;
    end

    sbs_front #(
        .NUM_SPIKE_IDS (NUM_SPIKE_IDS),
        .MAX_FANOUT    (MAX_FANOUT),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .spike_id    (spike_id),
        .table_row   (table_row),
        .table_col   (table_col),
        .table_entry (table_entry),
        .read_slot   (read_slot),
        .read_xy     (read_xy),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    sbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    sbs_back #(
        .NUM_SPIKE_IDS (NUM_SPIKE_IDS),
        .MAX_FANOUT    (MAX_FANOUT),
        .MAX_XY        (MAX_XY),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .overflow  (overflow),
        .bad_index (bad_index)
    );

endmodule

// File: hw/rtl/sbs_front.sv
// Front end: takes input transactions, classifies them and stages them for the queue.
module sbs_front #(
    parameter int NUM_SPIKE_IDS = sbs_pkg::DEF_NUM_SPIKE_IDS,
    parameter int MAX_FANOUT    = sbs_pkg::DEF_MAX_FANOUT,
    parameter int MAX_DEPTH     = sbs_pkg::DEF_MAX_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbs_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sbs_pkg::FUNC_W-1:0]          func,
    input  logic signed [sbs_pkg::SPIKE_W-1:0]  spike_id,
    input  logic [sbs_pkg::ROW_W-1:0]           table_row,
    input  logic [sbs_pkg::COL_W-1:0]           table_col,
    input  logic signed [sbs_pkg::ENTRY_W-1:0]  table_entry,
    input  logic [sbs_pkg::SLOT_W-1:0]          read_slot,
    input  logic [sbs_pkg::XY_W-1:0]            read_xy,
    output logic                                push_valid,
    input  logic                                push_ready,
    output sbs_pkg::cmd_t                       push_cmd
);

    sbs_pkg::cmd_t cmd_next;
    sbs_pkg::cmd_t cmd_reg;
    logic          vld_reg;
    logic          vld_next;
    logic          xy_bad;

    assign xy_bad = {1'b0, read_xy} >= cfg.xy;

    always_comb
    begin
        cmd_next       = '0;
        cmd_next.op    = sbs_pkg::OP_NOP;
        cmd_next.col   = table_col;
        cmd_next.entry = table_entry;
        cmd_next.slot  = read_slot;
        cmd_next.xy    = read_xy;
        cmd_next.row   = table_row;
        case (func)
            sbs_pkg::FUNC_WRITE:
            begin
                if (32'(table_row) >= NUM_SPIKE_IDS || 32'(table_col) >= MAX_FANOUT)
                    cmd_next.bad = 1'b1;
                else
                    cmd_next.op = sbs_pkg::OP_WRITE;
            end
            sbs_pkg::FUNC_CLEAR:
                cmd_next.op = sbs_pkg::OP_CLEAR;
            sbs_pkg::FUNC_SPIKE:
            begin
                cmd_next.row = spike_id[sbs_pkg::ROW_W-1:0];
                if (!spike_id[sbs_pkg::SPIKE_W-1])
                begin
                    if (32'(spike_id[sbs_pkg::ROW_W-1:0]) >= NUM_SPIKE_IDS)
                        cmd_next.bad = 1'b1;
                    else
                        cmd_next.op = sbs_pkg::OP_SPIKE;
                end
            end
            sbs_pkg::FUNC_READ_SLOT:
            begin
                if (xy_bad || 32'(read_slot) >= MAX_DEPTH)
                    cmd_next.bad = 1'b1;
                else
                    cmd_next.op = sbs_pkg::OP_READ_SLOT;
            end
            sbs_pkg::FUNC_READ_COUNT:
            begin
                if (xy_bad)
                    cmd_next.bad = 1'b1;
                else
                    cmd_next.op = sbs_pkg::OP_READ_COUNT;
            end
            default:
                cmd_next.op = sbs_pkg::OP_NOP;
        endcase
    end

    assign in_ready   = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
            vld_next = 1'b1;
        else if (push_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cmd_reg <= cmd_next;
    end

endmodule

// File: hw/rtl/sbs_queue.sv
// Short command queue between the front end and the back end.
module sbs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sbs_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sbs_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(sbs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sbs_pkg::QUEUE_DEPTH + 1);

    sbs_pkg::cmd_t    slot_reg [sbs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = fill_reg != CNT_W'(sbs_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hw/rtl/sbs_back.sv
// Back end: fanout table, bucket store, fill counters, divider and result register.
module sbs_back #(
    parameter int NUM_SPIKE_IDS = sbs_pkg::DEF_NUM_SPIKE_IDS,
    parameter int MAX_FANOUT    = sbs_pkg::DEF_MAX_FANOUT,
    parameter int MAX_XY        = sbs_pkg::DEF_MAX_XY,
    parameter int MAX_DEPTH     = sbs_pkg::DEF_MAX_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sbs_pkg::cfg_t                      cfg,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  sbs_pkg::cmd_t                      pop_cmd,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sbs_pkg::DATA_W-1:0]  read_data,
    output logic                               overflow,
    output logic                               bad_index
);

    localparam int TAB_DEPTH = NUM_SPIKE_IDS * MAX_FANOUT;
    localparam int BKT_DEPTH = MAX_XY * MAX_DEPTH;
    localparam int TA_W      = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int BA_W      = (BKT_DEPTH > 1) ? $clog2(BKT_DEPTH) : 1;
    localparam int XA_W      = (MAX_XY > 1) ? $clog2(MAX_XY) : 1;
    localparam int DIV_STEPS = sbs_pkg::QUOT_W;
    localparam int DC_W      = $clog2(DIV_STEPS + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_RDWAIT = 8'b0000_0100,
        S_TABREQ = 8'b0000_1000,
        S_TAB    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_CNTREQ = 8'b0100_0000,
        S_UPD    = 8'b1000_0000
    } state_t;

    // Memories.
    logic [sbs_pkg::ENTRY_W-1:0] tab_mem [TAB_DEPTH];
    logic [sbs_pkg::QUOT_W-1:0]  bkt_mem [BKT_DEPTH];
    logic [sbs_pkg::CNT_W-1:0]   cnt_mem [MAX_XY];
    logic [MAX_XY-1:0]           cnt_vld_reg;

    logic [sbs_pkg::ENTRY_W-1:0] tab_q;
    logic [sbs_pkg::QUOT_W-1:0]  bkt_q;
    logic [sbs_pkg::CNT_W-1:0]   cnt_q;
    logic                        cnt_qv_reg;

    state_t                      state_reg;
    state_t                      state_next;
    sbs_pkg::cmd_t               cmd_reg;
    logic [sbs_pkg::FAN_W-1:0]   k_reg;
    logic [sbs_pkg::FAN_W-1:0]   k_next;
    logic [7:0]                  div_rem_reg;
    logic [7:0]                  div_rem_next;
    logic [sbs_pkg::QUOT_W-1:0]  div_quo_reg;
    logic [sbs_pkg::QUOT_W-1:0]  div_quo_next;
    logic [DC_W-1:0]             div_cnt_reg;
    logic [DC_W-1:0]             div_cnt_next;
    logic                        ovf_reg;
    logic                        ovf_next;

    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic [sbs_pkg::DATA_W-1:0]  out_data_reg;
    logic                        out_ovf_reg;
    logic                        out_bad_reg;
    logic                        finish;
    logic [sbs_pkg::DATA_W-1:0]  fin_data;

    logic                        tab_we;
    logic                        tab_re;
    logic [TA_W-1:0]             tab_addr;
    logic                        bkt_we;
    logic                        bkt_re;
    logic [BA_W-1:0]             bkt_addr;
    logic                        cnt_we;
    logic                        cnt_re;
    logic [XA_W-1:0]             cnt_addr;
    logic [sbs_pkg::CNT_W-1:0]   cnt_wdata;
    logic                        cnt_clear;

    logic [sbs_pkg::CNT_W-1:0]   count;
    logic [7:0]                  trial;
    logic                        last_k;

    assign count  = cnt_qv_reg ? cnt_q : '0;
    assign trial  = {div_rem_reg[6:0], div_quo_reg[sbs_pkg::QUOT_W-1]};
    assign last_k = (k_reg + 1'b1) == cfg.fanout;

    assign pop_ready = (state_reg == S_IDLE) && (!out_vld_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_cnt_next = div_cnt_reg;
        ovf_next     = ovf_reg;
        finish       = 1'b0;
        fin_data     = '0;
        tab_we       = 1'b0;
        tab_re       = 1'b0;
        tab_addr     = TA_W'(32'(cmd_reg.row) * MAX_FANOUT + 32'(cmd_reg.col));
        bkt_we       = 1'b0;
        bkt_re       = 1'b0;
        bkt_addr     = BA_W'(32'(cmd_reg.xy) * MAX_DEPTH + 32'(cmd_reg.slot));
        cnt_we       = 1'b0;
        cnt_re       = 1'b0;
        cnt_addr     = XA_W'(cmd_reg.xy);
        cnt_wdata    = count + 1'b1;
        cnt_clear    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid && pop_ready)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    sbs_pkg::OP_WRITE:
                    begin
                        tab_we     = 1'b1;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    sbs_pkg::OP_CLEAR:
                    begin
                        cnt_clear  = 1'b1;
                        ovf_next   = 1'b0;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    sbs_pkg::OP_SPIKE:
                    begin
                        k_next = '0;
                        if (cfg.fanout == '0)
                        begin
                            finish     = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                            state_next = S_TABREQ;
                    end
                    sbs_pkg::OP_READ_SLOT, sbs_pkg::OP_READ_COUNT:
                    begin
                        cnt_re     = 1'b1;
                        bkt_re     = 1'b1;
                        state_next = S_RDWAIT;
                    end
                    default:
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                if (cmd_reg.op == sbs_pkg::OP_READ_COUNT)
                    fin_data = sbs_pkg::DATA_W'(count);
                else if (sbs_pkg::CNT_W'(cmd_reg.slot) < count
                         && sbs_pkg::DEP_W'(cmd_reg.slot) < cfg.depth)
                    fin_data = {1'b0, bkt_q};
                else
                    fin_data = '1;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_TABREQ:
            begin
                tab_addr   = TA_W'(32'(cmd_reg.row) * MAX_FANOUT + 32'(k_reg));
                tab_re     = 1'b1;
                state_next = S_TAB;
            end
            S_TAB:
            begin
                if (tab_q[sbs_pkg::ENTRY_W-1])
                begin
                    // Unused entry: skip to the next column.
                    k_next = k_reg + 1'b1;
                    if (last_k)
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_TABREQ;
                end
                else
                begin
                    div_rem_next = '0;
                    div_quo_next = tab_q[sbs_pkg::QUOT_W-1:0];
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                // One restoring step per cycle, most significant bit first.
                if (trial >= {1'b0, cfg.xy})
                begin
                    div_rem_next = trial - {1'b0, cfg.xy};
                    div_quo_next = {div_quo_reg[sbs_pkg::QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = trial;
                    div_quo_next = {div_quo_reg[sbs_pkg::QUOT_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DC_W'(DIV_STEPS - 1))
                    state_next = S_CNTREQ;
            end
            S_CNTREQ:
            begin
                cnt_addr   = XA_W'(div_rem_reg);
                cnt_re     = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cnt_addr = XA_W'(div_rem_reg);
                bkt_addr = BA_W'(32'(div_rem_reg) * MAX_DEPTH + 32'(count));
                if (count < sbs_pkg::CNT_W'(cfg.depth))
                    bkt_we = 1'b1;
                else
                    ovf_next = 1'b1;
                if (count != sbs_pkg::COUNT_SAT)
                    cnt_we = 1'b1;
                k_next = k_reg + 1'b1;
                if (last_k)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_TABREQ;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (finish)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
            cnt_vld_reg <= '0;
            cnt_qv_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
            if (cnt_re)
                cnt_qv_reg <= cnt_vld_reg[cnt_addr];
            if (cnt_clear)
                cnt_vld_reg <= '0;
            else if (cnt_we)
                cnt_vld_reg[cnt_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            cmd_reg <= pop_cmd;
        k_reg       <= k_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_cnt_reg <= div_cnt_next;
        if (finish)
        begin
            out_data_reg <= fin_data;
            out_ovf_reg  <= ovf_next;
            out_bad_reg  <= cmd_reg.bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_addr] <= cmd_reg.entry;
        if (tab_re)
            tab_q <= tab_mem[tab_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_addr] <= div_quo_reg;
        if (bkt_re)
            bkt_q <= bkt_mem[bkt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_addr] <= cnt_wdata;
        if (cnt_re)
            cnt_q <= cnt_mem[cnt_addr];
    end

    assign out_valid = out_vld_reg;
    assign read_data = out_data_reg;
    assign overflow  = out_ovf_reg;
    assign bad_index = out_bad_reg;

    // A waiting result is neither replaced nor lost.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> out_vld_reg && $stable(out_data_reg))
        else $error("result changed while stalled");

    // A clear leaves the overflow flag low.
    a_clear_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && cmd_reg.op == sbs_pkg::OP_CLEAR |=> !ovf_reg)
        else $error("overflow survived a clear");

    // The walk never reads past the columns in use.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TABREQ |-> k_reg < cfg.fanout)
        else $error("fanout walk overran");

    // The divider leaves a remainder below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CNTREQ |-> div_rem_reg < {1'b0, cfg.xy})
        else $error("remainder not below divisor");

    // A command is taken only when the result register is free.
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> !out_vld_reg)
        else $error("command taken over a pending result");

endmodule
